/* design/lda_gibbs_topic_sampler_top_defines.svh */
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler assertion macros
// Shared assertion shorthands for the sampler RTL, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LDA_GIBBS_TOPIC_SAMPLER_TOP_DEFINES_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define LGTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LGTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lgts_pkg.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler package
// Fixed-point constants, codes and the divider response type.
// ----------------------------------------------------------------------------
package lgts_pkg;

  // Ratios are unsigned Q0.24 fractions.
  localparam int unsigned FRAC_BITS = 24;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;
  // Cumulative weights and their total.
  localparam int unsigned CW_BITS = 48;

  localparam logic FUNC_INIT     = 1'b0;
  localparam logic FUNC_RESAMPLE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [1:0] REG_NUM_TOPICS = 2'd0;
  localparam logic [1:0] REG_NUM_WORDS  = 2'd1;
  localparam logic [1:0] REG_ALPHA      = 2'd2;
  localparam logic [1:0] REG_BETA       = 2'd3;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

endpackage

/* design/lgts_div.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler fraction divider
// Restoring divider giving a truncated Q0.24 quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module lgts_div #(
  parameter int unsigned DW = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  output lgts_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNTW = $clog2(lgts_pkg::FRAC_BITS + 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CNTW-1:0]                cnt_q, cnt_d;
  logic [DW-1:0]                  rem_q, rem_d;
  logic [DW-1:0]                  den_q, den_d;
  logic [lgts_pkg::FRAC_BITS-1:0] quot_q, quot_d;
  logic [DW:0]                    rem_sh;

  assign rem_sh = {rem_q, 1'b0};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      den_d = den_i;
      rem_d = num_i;
      cnt_d = CNTW'(lgts_pkg::FRAC_BITS);
      if (den_i == '0) begin
        quot_d = '0;
        done_d = 1'b1;
      end else if (num_i >= den_i) begin
        quot_d = lgts_pkg::FRAC_MAX;
        done_d = 1'b1;
      end else begin
        quot_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d  = DW'(rem_sh - {1'b0, den_q});
        quot_d = {quot_q[lgts_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[DW-1:0];
        quot_d = {quot_q[lgts_pkg::FRAC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* design/lda_gibbs_topic_sampler_top.sv */
// ----------------------------------------------------------------------------
// LDA collapsed Gibbs topic sampler
// This block holds the word-topic, document-topic, topic-total and
// document-total count tables of latent Dirichlet allocation and updates
// them one token item at a time. An init item draws its topic as
// floor(random_value * K / 65536) and adds it to the counts. A resample item
// removes the token under current_topic, weights each of the K topics by
// (nw+beta)/(nwsum+W*beta) * (nd+alpha)/(ndsum+K*alpha) in Q0.24 fixed point,
// picks the first topic whose running sum exceeds random_value/65536 of the
// total, and adds the token back under that topic. Out-of-range indexes or a
// zero count under the old topic give status 1 and leave every table as it
// was. The block takes one item at a time. The cost of a resample item is set
// by the one shared restoring divider, which produces one quotient bit per
// cycle and runs twice per topic (a ratio that saturates or has a zero
// divisor skips the bit loop). After reset the count tables are swept to
// zero, one entry per cycle; no item is taken during the sweep, while
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`include "lda_gibbs_topic_sampler_top_defines.svh"

module lda_gibbs_topic_sampler_top #(
  parameter int unsigned MAX_TOPICS = 64,
  parameter int unsigned MAX_WORDS  = 4096,
  parameter int unsigned MAX_DOCS   = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [9:0]  doc_index_i,
  input  logic [11:0] word_index_i,
  input  logic [5:0]  current_topic_i,
  input  logic [15:0] random_value_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  new_topic_o,
  output logic        status_o
);

  // Widths derived from the sizing parameters.
  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned TTW   = COUNT_BITS + 8;
  localparam int unsigned TW    = $clog2(MAX_TOPICS);
  localparam int unsigned KW    = $clog2(MAX_TOPICS + 1);
  localparam int unsigned WW    = $clog2(MAX_WORDS);
  localparam int unsigned WKW   = $clog2(MAX_WORDS + 1);
  localparam int unsigned DCW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int unsigned WT_N  = MAX_WORDS * MAX_TOPICS;
  localparam int unsigned DT_N  = MAX_DOCS * MAX_TOPICS;
  localparam int unsigned WTAW  = $clog2(WT_N);
  localparam int unsigned DTAW  = $clog2(DT_N);
  localparam int unsigned CLR_N = (WT_N > DT_N) ? WT_N : DT_N;
  localparam int unsigned CLRW  = $clog2(CLR_N);
  localparam int unsigned WBW   = WKW + 16;
  localparam int unsigned KAW   = KW + 16;
  localparam int unsigned DW0   = (TTW + 8 > WBW) ? TTW + 8 : WBW;
  localparam int unsigned DW    = DW0 + 1;
  localparam int unsigned CW    = lgts_pkg::CW_BITS;
  localparam int unsigned FB    = lgts_pkg::FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_REM_RD  = 4'd3;
  localparam logic [3:0] S_REM_WR  = 4'd4;
  localparam logic [3:0] S_SW_RD   = 4'd5;
  localparam logic [3:0] S_SW_LD   = 4'd6;
  localparam logic [3:0] S_SW_DIV1 = 4'd7;
  localparam logic [3:0] S_SW_DIV2 = 4'd8;
  localparam logic [3:0] S_SW_ACC  = 4'd9;
  localparam logic [3:0] S_U       = 4'd10;
  localparam logic [3:0] S_SR_RD   = 4'd11;
  localparam logic [3:0] S_SR_CMP  = 4'd12;
  localparam logic [3:0] S_ADD_RD  = 4'd13;
  localparam logic [3:0] S_ADD_WR  = 4'd14;

  // Configuration registers.
  logic [6:0]  num_topics_q;
  logic [12:0] num_words_q;
  logic [15:0] alpha_q;
  logic [15:0] beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_topics_q <= 7'd16;
      num_words_q  <= 13'd4096;
      alpha_q      <= 16'd800;
      beta_q       <= 16'd26;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lgts_pkg::REG_NUM_TOPICS: num_topics_q <= cfg_data_i[6:0];
        lgts_pkg::REG_NUM_WORDS:  num_words_q  <= cfg_data_i[12:0];
        lgts_pkg::REG_ALPHA:      alpha_q      <= cfg_data_i;
        lgts_pkg::REG_BETA:       beta_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective topic count and vocabulary size, at least 1 and at most the table sizes.
  logic [KW-1:0]  k_eff;
  logic [WKW-1:0] w_eff;

  always_comb begin
    if (num_topics_q == 7'd0) begin
      k_eff = KW'(1);
    end else if (32'(num_topics_q) > MAX_TOPICS) begin
      k_eff = KW'(MAX_TOPICS);
    end else begin
      k_eff = KW'(num_topics_q);
    end
    if (num_words_q == 13'd0) begin
      w_eff = WKW'(1);
    end else if (32'(num_words_q) > MAX_WORDS) begin
      w_eff = WKW'(MAX_WORDS);
    end else begin
      w_eff = WKW'(num_words_q);
    end
  end

  // Sequencer and datapath registers.
  logic [3:0]      state_q;
  logic [CLRW-1:0] clr_q;
  logic            out_valid_q;
  logic [5:0]      new_topic_q;
  logic            status_q;
  logic            func_q;
  logic [9:0]      doc_q;
  logic [11:0]     word_q;
  logic [5:0]      cur_q;
  logic [15:0]     rnd_q;
  logic [TW-1:0]   topic_q;
  logic [WBW-1:0]  wbeta_q;
  logic [KAW-1:0]  kalpha_q;
  logic [DW-1:0]   den2_q;
  logic [DW-1:0]   n2_q;
  logic [FB-1:0]   r1_q;
  logic [2*FB-1:0] prod_q;
  logic [CW-1:0]   total_q;
  logic [CW-1:0]   u_q;

  // Memory read data.
  logic [CB-1:0]  wt_rd_q;
  logic [CB-1:0]  dt_rd_q;
  logic [TTW-1:0] tt_rd_q;
  logic [CB-1:0]  dn_rd_q;
  logic [CW-1:0]  cw_rd_q;

  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  // Word-topic, document-topic and topic-total addresses follow the current topic register.
  logic [WTAW-1:0] wt_addr;
  logic [DTAW-1:0] dt_addr;
  logic [DCW-1:0]  doc_addr;

  assign wt_addr  = WTAW'(32'(word_q) * MAX_TOPICS + 32'(topic_q));
  assign dt_addr  = DTAW'(32'(doc_q) * MAX_TOPICS + 32'(topic_q));
  assign doc_addr = DCW'(doc_q);

  logic clearing, rem_wr, add_wr;
  assign clearing = (state_q == S_CLEAR);
  assign rem_wr   = (state_q == S_REM_WR) &&
                    (wt_rd_q != '0) && (dt_rd_q != '0) &&
                    (tt_rd_q != '0) && (dn_rd_q != '0);
  assign add_wr   = (state_q == S_ADD_WR);

  // Zeros while clearing, else saturating increments and plain decrements of the read counts.
  logic [CB-1:0]  wt_wd, dt_wd, dn_wd;
  logic [TTW-1:0] tt_wd;

  always_comb begin
    if (clearing) begin
      wt_wd = '0;
      dt_wd = '0;
      tt_wd = '0;
      dn_wd = '0;
    end else if (add_wr) begin
      wt_wd = (wt_rd_q == '1) ? wt_rd_q : CB'(wt_rd_q + 1'b1);
      dt_wd = (dt_rd_q == '1) ? dt_rd_q : CB'(dt_rd_q + 1'b1);
      tt_wd = (tt_rd_q == '1) ? tt_rd_q : TTW'(tt_rd_q + 1'b1);
      dn_wd = (dn_rd_q == '1) ? dn_rd_q : CB'(dn_rd_q + 1'b1);
    end else begin
      wt_wd = CB'(wt_rd_q - 1'b1);
      dt_wd = CB'(dt_rd_q - 1'b1);
      tt_wd = TTW'(tt_rd_q - 1'b1);
      dn_wd = CB'(dn_rd_q - 1'b1);
    end
  end

  logic wt_we, dt_we, tt_we, dn_we, cw_we;
  assign wt_we = (clearing && (32'(clr_q) < WT_N)) || rem_wr || add_wr;
  assign dt_we = (clearing && (32'(clr_q) < DT_N)) || rem_wr || add_wr;
  assign tt_we = (clearing && (32'(clr_q) < MAX_TOPICS)) || rem_wr || add_wr;
  assign dn_we = (clearing && (32'(clr_q) < MAX_DOCS)) || rem_wr || add_wr;
  assign cw_we = (state_q == S_SW_ACC);

  logic [WTAW-1:0] wt_wa;
  logic [DTAW-1:0] dt_wa;
  logic [TW-1:0]   tt_wa;
  logic [DCW-1:0]  dn_wa;

  assign wt_wa = clearing ? clr_q[WTAW-1:0] : wt_addr;
  assign dt_wa = clearing ? clr_q[DTAW-1:0] : dt_addr;
  assign tt_wa = clearing ? clr_q[TW-1:0]   : topic_q;
  assign dn_wa = clearing ? clr_q[DCW-1:0]  : doc_addr;

  // Count tables and the cumulative weight store.
  logic [CB-1:0]  wt_mem [WT_N];
  logic [CB-1:0]  dt_mem [DT_N];
  logic [TTW-1:0] tt_mem [MAX_TOPICS];
  logic [CB-1:0]  dn_mem [MAX_DOCS];
  logic [CW-1:0]  cw_mem [MAX_TOPICS];

  logic [CW-1:0] total_new;
  assign total_new = total_q + CW'(prod_q >> 8);

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd_q <= wt_mem[wt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) dt_mem[dt_wa] <= dt_wd;
    dt_rd_q <= dt_mem[dt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) tt_mem[tt_wa] <= tt_wd;
    tt_rd_q <= tt_mem[topic_q];
  end

  always_ff @(posedge clk_i) begin
    if (dn_we) dn_mem[dn_wa] <= dn_wd;
    dn_rd_q <= dn_mem[doc_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) cw_mem[topic_q] <= total_new;
    cw_rd_q <= cw_mem[topic_q];
  end

  // Shared divider: first the word ratio, then the document ratio.
  logic               div_start;
  logic [DW-1:0]      div_num, div_den;
  lgts_pkg::div_rsp_t div_rsp;
  logic [DW-1:0]      n1, den1;

  assign n1   = DW'({wt_rd_q, 8'd0}) + DW'(beta_q);
  assign den1 = DW'({tt_rd_q, 8'd0}) + DW'(wbeta_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = n1;
    div_den   = den1;
    if (state_q == S_SW_LD) begin
      div_start = 1'b1;
    end else if (state_q == S_SW_DIV1 && div_rsp.done) begin
      div_start = 1'b1;
      div_num   = n2_q;
      div_den   = den2_q;
    end
  end

  lgts_div #(
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp)
  );

  // Products, each registered before use.
  logic [16+KW-1:0] init_prod;
  logic [CW+15:0]   u_prod;
  logic             range_err;
  logic             last_topic;

  assign init_prod  = (16+KW)'(rnd_q) * (16+KW)'(k_eff);
  assign u_prod     = (CW+16)'(total_q) * (CW+16)'(rnd_q);
  assign range_err  = (32'(doc_q) >= MAX_DOCS) || (32'(word_q) >= 32'(w_eff)) ||
                      ((func_q == lgts_pkg::FUNC_RESAMPLE) && (32'(cur_q) >= 32'(k_eff)));
  assign last_topic = (32'(topic_q) + 32'd1 == 32'(k_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= CLRW'(clr_q + 1'b1);
          if (clr_q == CLRW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (range_err) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (func_q == lgts_pkg::FUNC_INIT) begin
            state_q <= S_ADD_RD;
          end else begin
            state_q <= S_REM_RD;
          end
        end
        S_REM_RD: state_q <= S_REM_WR;
        S_REM_WR: begin
          if (rem_wr) begin
            state_q <= S_SW_RD;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SW_RD:   state_q <= S_SW_LD;
        S_SW_LD:   state_q <= S_SW_DIV1;
        S_SW_DIV1: if (div_rsp.done) state_q <= S_SW_DIV2;
        S_SW_DIV2: if (div_rsp.done) state_q <= S_SW_ACC;
        S_SW_ACC:  state_q <= last_topic ? S_U : S_SW_RD;
        S_U:       state_q <= S_SR_RD;
        S_SR_RD:   state_q <= S_SR_CMP;
        S_SR_CMP: begin
          if (u_q < cw_rd_q || last_topic) begin
            state_q <= S_ADD_RD;
          end else begin
            state_q <= S_SR_RD;
          end
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      doc_q  <= doc_index_i;
      word_q <= word_index_i;
      cur_q  <= current_topic_i;
      rnd_q  <= random_value_i;
    end
    case (state_q)
      S_CHECK: begin
        new_topic_q <= cur_q;
        status_q    <= lgts_pkg::STATUS_ERR;
        wbeta_q     <= WBW'(w_eff) * WBW'(beta_q);
        if (func_q == lgts_pkg::FUNC_INIT) begin
          topic_q <= TW'(init_prod >> 16);
        end else begin
          topic_q <= TW'(cur_q);
        end
      end
      S_REM_RD: kalpha_q <= KAW'(k_eff) * KAW'(alpha_q);
      S_REM_WR: begin
        den2_q  <= DW'({CB'(dn_rd_q - 1'b1), 8'd0}) + DW'(kalpha_q);
        topic_q <= '0;
        total_q <= '0;
      end
      S_SW_LD: n2_q <= DW'({dt_rd_q, 8'd0}) + DW'(alpha_q);
      S_SW_DIV1: if (div_rsp.done) r1_q <= div_rsp.quot;
      S_SW_DIV2: if (div_rsp.done) prod_q <= (2*FB)'(r1_q) * (2*FB)'(div_rsp.quot);
      S_SW_ACC: begin
        total_q <= total_new;
        topic_q <= last_topic ? '0 : TW'(topic_q + 1'b1);
      end
      S_U: u_q <= u_prod[CW+15:16];
      S_SR_CMP: begin
        if (!(u_q < cw_rd_q)) begin
          topic_q <= last_topic ? TW'(cur_q) : TW'(topic_q + 1'b1);
        end
      end
      S_ADD_WR: begin
        new_topic_q <= 6'(topic_q);
        status_q    <= lgts_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign new_topic_o = new_topic_q;
  assign status_o    = status_q;

  // The divider only reports back while the sweep waits on it.
  `LGTS_ASSERT_IMPL(a_div_done_in_wait, div_rsp.done,
    state_q == S_SW_DIV1 || state_q == S_SW_DIV2, "divider done outside a wait state")
  // Every weight written belongs to a topic in use.
  `LGTS_ASSERT_IMPL(a_sweep_in_range, state_q == S_SW_ACC,
    32'(topic_q) < 32'(k_eff), "sweep topic beyond topic count")
  // A successful result always carries a topic in use.
  `LGTS_ASSERT_NEXT(a_ok_topic_in_range, state_q == S_ADD_WR,
    out_valid_q && status_q == lgts_pkg::STATUS_OK && 32'(new_topic_q) < 32'(k_eff),
    "result topic beyond topic count")

endmodule

/* tb/lda_gibbs_topic_sampler_top_tb.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler testbench
// Drives init and resample token items into the sampler under several
// configurations and checks every result item against a cycle-free predictor
// of the count tables and the fixed-point topic draw. Both sides of the
// item handshake idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lda_gibbs_topic_sampler_top_tb;

  localparam int unsigned NUM_TOPICS_MAX = 64;
  localparam int unsigned NUM_WORDS_MAX  = 4096;
  localparam int unsigned NUM_DOCS       = 1024;
  localparam longint unsigned CNT_SAT    = 64'hFFFF;
  localparam longint unsigned TOT_SAT    = 64'hFF_FFFF;
  // The count sweep after reset, with nothing accepted, and a K=64 resample
  // with a long output stall both stay far below this limit.
  localparam int unsigned WATCHDOG_LIMIT = 1200000;

  typedef struct {
    logic [5:0] topic;
    logic       status;
  } topic_result_t;

  typedef struct {
    logic [9:0]  doc;
    logic [11:0] word;
    logic [5:0]  topic;
  } token_t;

  // Scoreboard: keeps its own copy of the count tables and registers,
  // predicts the result of each accepted item and checks results in order.
  class topic_scoreboard;
    int unsigned     word_topic[int];
    int unsigned     doc_topic[int];
    longint unsigned topic_total[NUM_TOPICS_MAX];
    longint unsigned doc_total[NUM_DOCS];
    int unsigned     k_eff = 16;
    int unsigned     w_eff = 4096;
    longint unsigned alpha = 800;
    longint unsigned beta  = 26;
    topic_result_t   expected_q[$];
    int unsigned     mismatches = 0;
    int unsigned     checked = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        lgts_pkg::REG_NUM_TOPICS: begin
          k_eff = 32'(value[6:0]);
          if (k_eff == 0) k_eff = 1;
          if (k_eff > NUM_TOPICS_MAX) k_eff = NUM_TOPICS_MAX;
        end
        lgts_pkg::REG_NUM_WORDS: begin
          w_eff = 32'(value[12:0]);
          if (w_eff == 0) w_eff = 1;
          if (w_eff > NUM_WORDS_MAX) w_eff = NUM_WORDS_MAX;
        end
        lgts_pkg::REG_ALPHA: alpha = 64'(value);
        lgts_pkg::REG_BETA:  beta  = 64'(value);
        default: ;
      endcase
    endfunction

    function int unsigned wt(int unsigned word, int unsigned t);
      return word_topic.exists(word * 64 + t) ? word_topic[word * 64 + t] : 0;
    endfunction

    function int unsigned dt(int unsigned doc, int unsigned t);
      return doc_topic.exists(doc * 64 + t) ? doc_topic[doc * 64 + t] : 0;
    endfunction

    // Q0.24 quotient by restoring division; saturates, zero divisor gives 0.
    function longint unsigned q24_ratio(longint unsigned num, longint unsigned den);
      longint unsigned rem;
      longint unsigned q;
      rem = num;
      q = 0;
      if (den == 0) return 0;
      if (num >= den) return (64'd1 << lgts_pkg::FRAC_BITS) - 1;
      for (int i = 0; i < lgts_pkg::FRAC_BITS; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      return q;
    endfunction

    function void add_token(int unsigned doc, int unsigned word, int unsigned t);
      int unsigned c;
      c = wt(word, t);
      word_topic[word * 64 + t] = (c < CNT_SAT) ? c + 1 : c;
      c = dt(doc, t);
      doc_topic[doc * 64 + t] = (c < CNT_SAT) ? c + 1 : c;
      if (topic_total[t] < TOT_SAT) topic_total[t]++;
      if (doc_total[doc] < CNT_SAT) doc_total[doc]++;
    endfunction

    function void expect_result(topic_result_t res);
      expected_q = {expected_q, res};
    endfunction

    // Notes an accepted item and returns its predicted result.
    function topic_result_t note_item(logic func, logic [9:0] doc, logic [11:0] word,
                                      logic [5:0] cur, logic [15:0] rnd);
      topic_result_t   res;
      longint unsigned cum[NUM_TOPICS_MAX];
      longint unsigned total, u, den_doc, n1, n2, den_word;
      int unsigned     pick;
      res.topic = cur;
      res.status = lgts_pkg::STATUS_ERR;
      if (word >= w_eff) begin
        expect_result(res);
        return res;
      end
      if (func == lgts_pkg::FUNC_INIT) begin
        pick = 32'((longint'(rnd) * k_eff) >> 16);
        add_token(doc, word, pick);
        res.topic = 6'(pick);
        res.status = lgts_pkg::STATUS_OK;
        expect_result(res);
        return res;
      end
      if (cur >= k_eff || wt(word, cur) == 0 || dt(doc, cur) == 0 ||
          topic_total[cur] == 0 || doc_total[doc] == 0) begin
        expect_result(res);
        return res;
      end
      word_topic[word * 64 + cur]--;
      doc_topic[doc * 64 + cur]--;
      topic_total[cur]--;
      doc_total[doc]--;
      den_doc = (doc_total[doc] << 8) + k_eff * alpha;
      total = 0;
      for (int t = 0; t < k_eff; t++) begin
        n1 = (longint'(wt(word, t)) << 8) + beta;
        n2 = (longint'(dt(doc, t)) << 8) + alpha;
        den_word = (topic_total[t] << 8) + w_eff * beta;
        total += (q24_ratio(n1, den_word) * q24_ratio(n2, den_doc)) >> 8;
        cum[t] = total;
      end
      u = (total * rnd) >> 16;
      pick = 32'(cur);
      for (int t = 0; t < k_eff; t++) begin
        if (u < cum[t]) begin
          pick = t;
          break;
        end
      end
      add_token(doc, word, pick);
      res.topic = 6'(pick);
      res.status = lgts_pkg::STATUS_OK;
      expect_result(res);
      return res;
    endfunction

    function void check_result(logic [5:0] topic, logic status);
      topic_result_t exp_res;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result topic=%0d status=%0d with nothing expected", topic, status);
        return;
      end
      exp_res = expected_q.pop_front();
      if (topic !== exp_res.topic || status !== exp_res.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected topic=%0d status=%0d, got topic=%0d status=%0d",
                   checked, exp_res.topic, exp_res.status, topic, status);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [9:0]  doc_index_i = '0;
  logic [11:0] word_index_i = '0;
  logic [5:0]  current_topic_i = '0;
  logic [15:0] random_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  new_topic_o;
  logic        status_o;

  lda_gibbs_topic_sampler_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .doc_index_i, .word_index_i,
    .current_topic_i, .random_value_i,
    .out_valid_o, .out_stall_i, .new_topic_o, .status_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  topic_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned resample_ok = 0;
  int unsigned phases_run = 0;
  bit          sender_gaps = 1'b1;
  int unsigned stall_pct = 20;
  bit          long_hold_req = 1'b0;
  token_t      tokens[$];
  logic [9:0]  doc_pool[8];
  logic [11:0] word_pool[8];

  // Results are sampled with the values present just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(new_topic_o, status_o);
      results_seen++;
    end
  end

  // Receiver: random stall with short and rare long stretches. A long hold
  // requested by the stimulus is counted here, in cycles.
  int unsigned hold_cycles = 0;
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_cycles <= 600;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_cycles <= $urandom_range(20, 150);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: counts cycles without any accepted item on either side.
  int unsigned idle_cycles = 0;
  int unsigned last_progress = 0;
  always @(posedge clk_i) begin
    if (items_sent + results_seen != last_progress) begin
      last_progress <= items_sent + results_seen;
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("lda_gibbs_topic_sampler_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    sb.set_reg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one item and returns at the edge where it is accepted, with
  // valid still high; the next call or the idle wait decides what follows.
  task automatic send_token(input logic func, input logic [9:0] doc,
                            input logic [11:0] word, input logic [5:0] cur,
                            input logic [15:0] rnd, output topic_result_t res);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    gap = 0;
    if (sender_gaps)
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    doc_index_i <= doc;
    word_index_i <= word;
    current_topic_i <= cur;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    res = sb.note_item(func, doc, word, cur, rnd);
    items_sent++;
    if (func == lgts_pkg::FUNC_RESAMPLE && res.status == lgts_pkg::STATUS_OK) resample_ok++;
  endtask

  // Sender pause: no valid until every expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] k, input logic [15:0] w,
                           input logic [15:0] a, input logic [15:0] b);
    wait_idle();
    write_reg(lgts_pkg::REG_NUM_TOPICS, k);
    write_reg(lgts_pkg::REG_NUM_WORDS, w);
    write_reg(lgts_pkg::REG_ALPHA, a);
    write_reg(lgts_pkg::REG_BETA, b);
    tokens.delete();
    foreach (doc_pool[i]) doc_pool[i] = 10'($urandom_range(0, NUM_DOCS - 1));
    foreach (word_pool[i]) word_pool[i] = 12'($urandom_range(0, sb.w_eff - 1));
    doc_pool[0] = 10'(NUM_DOCS - 1);
    word_pool[0] = 12'(sb.w_eff - 1);
    phases_run++;
  endtask

  // Mostly well-formed traffic: inits on a small pool of documents and words
  // so that counts build up, and resamples of tokens that really hold their
  // topic. The rest is noise over the full field ranges.
  task automatic run_tokens(input int unsigned n);
    topic_result_t res;
    token_t        tok;
    int unsigned   r;
    int unsigned   idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_token(1'($urandom_range(0, 1)), 10'($urandom), 12'($urandom), 6'($urandom),
                   16'($urandom), res);
      end else if (r < 55 || tokens.size() == 0) begin
        tok.doc = doc_pool[$urandom_range(0, 7)];
        tok.word = word_pool[$urandom_range(0, 7)];
        send_token(lgts_pkg::FUNC_INIT, tok.doc, tok.word, 6'($urandom), 16'($urandom), res);
        tok.topic = res.topic;
        if (res.status == lgts_pkg::STATUS_OK) begin
          if (tokens.size() >= 64) tokens[$urandom_range(0, 63)] = tok;
          else tokens = {tokens, tok};
        end
      end else begin
        idx = $urandom_range(0, tokens.size() - 1);
        tok = tokens[idx];
        send_token(lgts_pkg::FUNC_RESAMPLE, tok.doc, tok.word, tok.topic, 16'($urandom), res);
        if (res.status == lgts_pkg::STATUS_OK) tokens[idx].topic = res.topic;
      end
    end
  endtask

  initial begin
    topic_result_t res;
    logic [5:0]    held;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset configuration (K=16, W=4096). The first
    // item waits out the clearing sweep of the count tables.
    send_token(lgts_pkg::FUNC_INIT, 10'd0, 12'd0, 6'd63, 16'h0000, res);
    send_token(lgts_pkg::FUNC_INIT, 10'd1023, 12'd4095, 6'd0, 16'hFFFF, res);
    send_token(lgts_pkg::FUNC_INIT, 10'd0, 12'd0, 6'd0, 16'h8000, res);
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd0, 12'd0, 6'd0, 16'h0000, res);
    held = res.topic;
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd0, 12'd0, held, 16'hFFFF, res);
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd1023, 12'd4095, 6'd15, 16'h1234, res);
    // Topic outside K, and a resample of a token that was never counted.
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd0, 12'd0, 6'd63, 16'h4000, res);
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd5, 12'd7, 6'd0, 16'h4000, res);

    // K=1, W=1 via written zeros, zero priors: every weight is zero once
    // the only token is removed, so the old topic must be kept.
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    send_token(lgts_pkg::FUNC_INIT, 10'd3, 12'd0, 6'd0, 16'hFFFF, res);
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd3, 12'd0, 6'd0, 16'h8000, res);
    send_token(lgts_pkg::FUNC_INIT, 10'd3, 12'd1, 6'd0, 16'h0001, res);
    send_token(lgts_pkg::FUNC_RESAMPLE, 10'd3, 12'd4095, 6'd0, 16'h0001, res);
    run_tokens(40);

    configure(16'd4, 16'd100, 16'd800, 16'd26);
    stall_pct = 0;
    run_tokens(350);

    // An oversized word count clamps to the maximum; largest priors.
    configure(16'd8, 16'd8191, 16'hFFFF, 16'hFFFF);
    stall_pct = 30;
    run_tokens(300);

    // K=64 is slow, so only a few items here.
    configure(16'd127, 16'd4096, 16'd256, 16'd1);
    run_tokens(20);

    configure(16'd2, 16'd4095, 16'd1, 16'hFFFF);
    sender_gaps = 1'b0;
    stall_pct = 10;
    run_tokens(400);

    configure(16'd5, 16'd50, 16'($urandom), 16'($urandom));
    sender_gaps = 1'b1;
    stall_pct = 40;
    run_tokens(400);

    // Long output hold while items keep being offered back to back.
    configure(16'd3, 16'd4096, 16'd800, 16'd26);
    stall_pct = 15;
    sender_gaps = 1'b0;
    long_hold_req <= 1'b1;
    run_tokens(10);
    sender_gaps = 1'b1;
    run_tokens(300);

    wait_idle();
    $display("Covered %0d items over %0d configurations, %0d successful resamples,",
             items_sent, phases_run + 1, resample_ok);
    $display("%0d results checked, %0d mismatches.", results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lda_gibbs_topic_sampler_top_tb passed");
    end else begin
      $display("lda_gibbs_topic_sampler_top_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/lgts_pkg.sv
design/lgts_div.sv
design/lda_gibbs_topic_sampler_top.sv
tb/lda_gibbs_topic_sampler_top_tb.sv
